>>> design/charlieplex_scan_refresh_core_assert.svh
// ----------------------------------------------------------------------------
// Charlieplex scan refresh assertion macros
// Shorthand for the concurrent checks of the scan refresh core. The module
// that uses them provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef CHARLIEPLEX_SCAN_REFRESH_CORE_ASSERT_SVH
`define CHARLIEPLEX_SCAN_REFRESH_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPSR_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPSR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cpsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Charlieplex scan refresh package
// Field widths, stream packing offsets, command codes and the request types
// shared by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package cpsr_pkg;

  // Default geometry of the matrix.
  localparam int PORT_WIDTH_DEF   = 8;
  localparam int PORT_COUNT_DEF   = 3;
  localparam int BUFFER_COUNT_DEF = 2;

  // Field widths.
  localparam int CMD_W      = 2;
  localparam int SEL_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int PORT_IDX_W = 2;
  localparam int LINE_IDX_W = 5;
  localparam int OUT_PIN_W  = 24;

  // Input tdata packing, lowest field first.
  localparam int BSEL_LSB  = 0;
  localparam int DATA_LSB  = BSEL_LSB + SEL_W;
  localparam int PORT_LSB  = DATA_LSB + BYTE_W;
  localparam int LINE_LSB  = PORT_LSB + PORT_IDX_W;
  localparam int MASK_LSB  = LINE_LSB + LINE_IDX_W;
  localparam int SHOW_LSB  = MASK_LSB + BYTE_W;
  localparam int S_TDATA_W = 32;

  // Output tdata packing, lowest field first.
  localparam int EN_LSB       = 0;
  localparam int LEVEL_LSB    = EN_LSB + OUT_PIN_W;
  localparam int LINE_OUT_LSB = LEVEL_LSB + OUT_PIN_W;
  localparam int M_TDATA_W    = 56;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INVERT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd3;

  // One checked request as it waits in the queue.
  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [SEL_W-1:0]      bsel;
    logic [BYTE_W-1:0]     data;
    logic [PORT_IDX_W-1:0] port;
    logic [LINE_IDX_W-1:0] line;
    logic [BYTE_W-1:0]     mask;
    logic                  show;
  } cpsr_op_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic     valid;
    cpsr_op_t op;
  } cpsr_head_t;

  // Back end status.
  typedef struct packed {
    logic clearing;
    logic idle;
  } cpsr_stat_t;

endpackage
`default_nettype wire

>>> design/charlieplex_scan_refresh_core.sv
// Tick path: an accepted request is queued, popped by the back end in IDLE, read
// in READ and registered as a result in MODIFY once the output register is free.
// Sequencing: a tick or masked write passes IDLE, READ and MODIFY (a tick waits
// while the output is held), a fill sweeps all rows in FILL and an invert runs
// READ and MODIFY per row. Reset: synchronous; afterwards a clearing pass over all
// BUFFER_COUNT * LINES rows (48 by default) zeroes the frame store before requests.
`default_nettype none
`include "charlieplex_scan_refresh_core_assert.svh"
// ----------------------------------------------------------------------------
// Charlieplex scan refresh core
// Double buffered charlieplexed LED matrix scanner: a front end checks and
// queues requests, a back end updates the frame store and drives the pins.
// ----------------------------------------------------------------------------
module charlieplex_scan_refresh_core #(
  parameter int PORT_WIDTH   = cpsr_pkg::PORT_WIDTH_DEF,
  parameter int PORT_COUNT   = cpsr_pkg::PORT_COUNT_DEF,
  parameter int BUFFER_COUNT = cpsr_pkg::BUFFER_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // buffer_sel[1:0], fill_value[9:2], port_index[11:10], line_index[16:12],
  // bit_mask[24:17], show_after[25], zeros above
  input  logic [cpsr_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd[1:0]
  input  logic [cpsr_pkg::CMD_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // drive_enable[23:0], drive_level[47:24], active_line[52:48], zeros above
  output logic [cpsr_pkg::M_TDATA_W-1:0] m_tdata,
  // frame_wrap
  output logic                           m_tlast
);

  import cpsr_pkg::*;

  localparam int LINES = PORT_WIDTH * PORT_COUNT;

  cpsr_head_t head;
  cpsr_stat_t stat;
  logic       pop;

  // Request checking and queueing.
  cpsr_front #(
    .PORT_COUNT   (PORT_COUNT),
    .BUFFER_COUNT (BUFFER_COUNT),
    .LINES        (LINES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  // Frame store sequencing and pin drive.
  cpsr_back #(
    .PORT_WIDTH   (PORT_WIDTH),
    .PORT_COUNT   (PORT_COUNT),
    .BUFFER_COUNT (BUFFER_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // The back end only takes a request when one is queued and it is idle.
  `CPSR_ASSERT_SAME(a_pop_legal, pop, head.valid && stat.idle, "pop without request")

  // No request is executed while the frame store is still being cleared.
  `CPSR_ASSERT_SAME(a_no_pop_clear, stat.clearing, !pop, "pop during clearing pass")

  // A frame ends only on the last scan line.
  `CPSR_ASSERT_SAME(a_wrap_line, m_tvalid && m_tlast,
    m_tdata[LINE_OUT_LSB +: LINE_IDX_W] == LINE_IDX_W'(LINES - 1), "wrap off last line")

endmodule
`default_nettype wire

>>> design/cpsr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Charlieplex scan refresh RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module cpsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/cpsr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Charlieplex scan refresh front end
// Accepts stream requests, drops those that address a buffer or a location
// that does not exist, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module cpsr_front #(
  parameter int PORT_COUNT   = 3,
  parameter int BUFFER_COUNT = 2,
  parameter int LINES        = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cpsr_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [cpsr_pkg::CMD_W-1:0]       s_tuser,
  output cpsr_pkg::cpsr_head_t             head,
  input  logic                             pop
);

  import cpsr_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  cpsr_op_t          in_op;
  logic              sel_ok;
  logic              addr_ok;
  logic              keep;
  logic              push;
  cpsr_op_t          entries [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // Unpack the request fields.
  always_comb begin
    in_op.cmd  = s_tuser;
    in_op.bsel = s_tdata[BSEL_LSB +: SEL_W];
    in_op.data = s_tdata[DATA_LSB +: BYTE_W];
    in_op.port = s_tdata[PORT_LSB +: PORT_IDX_W];
    in_op.line = s_tdata[LINE_LSB +: LINE_IDX_W];
    in_op.mask = s_tdata[MASK_LSB +: BYTE_W];
    in_op.show = s_tdata[SHOW_LSB];
  end

  // Classify: ticks always run, other commands need a real buffer, and a
  // masked write also needs a real port and line.
  assign sel_ok  = 32'(in_op.bsel) < BUFFER_COUNT;
  assign addr_ok = (32'(in_op.port) < PORT_COUNT) && (32'(in_op.line) < LINES);
  assign keep    = (in_op.cmd == CMD_TICK) ||
                   (sel_ok && ((in_op.cmd != CMD_WRITE) || addr_ok));

  assign s_tready = (count != CNT_W'(QDEPTH));
  assign push     = s_tvalid && s_tready && keep;

  // Queue occupancy.
  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_op;
    end
  end

  assign head.valid = (count != '0);
  assign head.op    = entries[rd_ptr];

endmodule
`default_nettype wire

>>> design/cpsr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Charlieplex scan refresh back end
// Sequencer over the frame store: clears it after reset, runs fills,
// inversions and masked writes row by row, and turns ticks into pin drive
// results held in an output register.
// ----------------------------------------------------------------------------
module cpsr_back #(
  parameter int PORT_WIDTH   = 8,
  parameter int PORT_COUNT   = 3,
  parameter int BUFFER_COUNT = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cpsr_pkg::cpsr_head_t           head,
  output logic                           pop,
  output cpsr_pkg::cpsr_stat_t           stat,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cpsr_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast
);

  import cpsr_pkg::*;

  localparam int LINES  = PORT_WIDTH * PORT_COUNT;
  localparam int ROW_W  = PORT_WIDTH * PORT_COUNT;
  localparam int DEPTH  = BUFFER_COUNT * LINES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LINE_W = $clog2(LINES);
  localparam int EXT_W  = (ROW_W > OUT_PIN_W) ? ROW_W : OUT_PIN_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_MODIFY = 3'd4;

  logic [2:0]            state;
  cpsr_op_t              op;
  logic [LINE_W-1:0]     row_cnt;
  logic [ADDR_W-1:0]     clr_cnt;
  logic [LINE_W-1:0]     scan_line;
  logic [SEL_W-1:0]      shown_buffer;
  logic [SEL_W-1:0]      pending_buffer;
  logic [OUT_PIN_W-1:0]  out_en;
  logic [OUT_PIN_W-1:0]  out_level;
  logic [LINE_IDX_W-1:0] out_line;
  logic                  out_wrap;

  logic [SEL_W-1:0]      acc_sel;
  logic [LINE_W-1:0]     acc_line;
  logic [ADDR_W-1:0]     acc_addr;
  logic [PORT_WIDTH-1:0] word_data;
  logic [PORT_WIDTH-1:0] word_mask;
  logic [ROW_W-1:0]      fill_row;
  logic [ROW_W-1:0]      mask_row;
  logic [ROW_W-1:0]      data_row;
  logic [ROW_W-1:0]      rd_data;
  logic [ROW_W-1:0]      wr_data;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [EXT_W-1:0]      row_ext;
  logic [OUT_PIN_W-1:0]  sink;
  logic                  last_row;
  logic                  line_wrap;
  logic                  out_free;
  logic                  tick_done;

  // Row address of the current request: ticks read the shown buffer at the
  // scan line, masked writes their own line, fill and invert sweep rows.
  always_comb begin
    unique case (op.cmd)
      CMD_TICK: begin
        acc_sel  = shown_buffer;
        acc_line = scan_line;
      end
      CMD_WRITE: begin
        acc_sel  = op.bsel;
        acc_line = LINE_W'(op.line);
      end
      default: begin
        acc_sel  = op.bsel;
        acc_line = row_cnt;
      end
    endcase
    acc_addr = ADDR_W'(32'(acc_sel) * LINES + 32'(acc_line));
  end

  // Row data for fills and masked writes, kept to the port width.
  always_comb begin
    word_data = PORT_WIDTH'(op.data);
    word_mask = PORT_WIDTH'(op.mask);
    fill_row  = {PORT_COUNT{word_data}};
    mask_row  = ROW_W'(word_mask) << (32'(op.port) * PORT_WIDTH);
    data_row  = ROW_W'(word_data & word_mask) << (32'(op.port) * PORT_WIDTH);
  end

  // Memory write selection.
  always_comb begin
    ram_re    = (state == ST_READ);
    ram_we    = (state == ST_CLEAR) || (state == ST_FILL) ||
                ((state == ST_MODIFY) && (op.cmd != CMD_TICK));
    ram_waddr = (state == ST_CLEAR) ? clr_cnt : acc_addr;
    if (state == ST_CLEAR) begin
      wr_data = '0;
    end else if (state == ST_FILL) begin
      wr_data = fill_row;
    end else if (op.cmd == CMD_INVERT) begin
      wr_data = ~rd_data;
    end else begin
      wr_data = (rd_data & ~mask_row) | data_row;
    end
  end

  cpsr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_data),
    .re    (ram_re),
    .raddr (acc_addr),
    .rdata (rd_data)
  );

  // Pin drive for a tick: stored sources plus the sink pin, sink driven low.
  always_comb begin
    row_ext = EXT_W'(rd_data);
    for (int i = 0; i < OUT_PIN_W; i++) begin
      sink[i] = (32'(scan_line) == i);
    end
  end

  assign last_row  = (row_cnt == LINE_W'(LINES - 1));
  assign line_wrap = (scan_line == LINE_W'(LINES - 1));
  assign out_free  = !m_tvalid || m_tready;
  assign tick_done = (state == ST_MODIFY) && (op.cmd == CMD_TICK) && out_free;
  assign pop       = (state == ST_IDLE) && head.valid;

  // Sequencer and scan state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      row_cnt        <= '0;
      clr_cnt        <= '0;
      scan_line      <= '0;
      shown_buffer   <= '0;
      pending_buffer <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // The result register fills on a finished tick and empties when taken.
      if (tick_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (head.valid) begin
            row_cnt <= '0;
            state   <= (head.op.cmd == CMD_FILL) ? ST_FILL : ST_READ;
          end
        end
        ST_FILL: begin
          row_cnt <= row_cnt + LINE_W'(1);
          if (last_row) begin
            pending_buffer <= op.bsel;
            state          <= ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_MODIFY;
        end
        ST_MODIFY: begin
          unique case (op.cmd)
            CMD_TICK: begin
              if (out_free) begin
                if (line_wrap) begin
                  scan_line    <= '0;
                  shown_buffer <= pending_buffer;
                end else begin
                  scan_line <= scan_line + LINE_W'(1);
                end
                state <= ST_IDLE;
              end
            end
            CMD_INVERT: begin
              if (last_row) begin
                pending_buffer <= op.bsel;
                state          <= ST_IDLE;
              end else begin
                row_cnt <= row_cnt + LINE_W'(1);
                state   <= ST_READ;
              end
            end
            CMD_WRITE: begin
              if (op.show) begin
                pending_buffer <= op.bsel;
              end
              state <= ST_IDLE;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      op <= head.op;
    end
    if (tick_done) begin
      out_en    <= row_ext[OUT_PIN_W-1:0] | sink;
      out_level <= ~sink;
      out_line  <= LINE_IDX_W'(scan_line);
      out_wrap  <= line_wrap;
    end
  end

  assign m_tdata       = M_TDATA_W'({out_line, out_level, out_en});
  assign m_tlast       = out_wrap;
  assign stat.clearing = (state == ST_CLEAR);
  assign stat.idle     = (state == ST_IDLE);

endmodule
`default_nettype wire
